>>> rtl/isu_pkg.sv
// shared types and constants of the integer set table unit
`timescale 1ns / 1ps

package isu_pkg;

    localparam int MODE_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;
    localparam int DEF_CAPACITY = 64;
    localparam int QDEPTH       = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_ERASE,
        OP_LOOKUP,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

endpackage

>>> rtl/isu_front.sv
// input register stage that takes transfers and decodes the operation
`timescale 1ns / 1ps

module isu_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [isu_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [isu_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_full,
    output logic                                o_push,
    output isu_pkg::t_cmd                       o_cmd
);
    import isu_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    logic accept;

    function automatic t_op decode_mode(input logic [MODE_W-1:0] mode);
        t_op op;
        unique case (mode)
            MODE_INSERT: op = OP_INSERT;
            MODE_ERASE:  op = OP_ERASE;
            MODE_LOOKUP: op = OP_LOOKUP;
            default:     op = OP_NONE;
        endcase
        return op;
    endfunction

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && i_full);
        end
        if (accept) begin
            r_cmd.op    <= decode_mode(i_mode);
            r_cmd.value <= i_value;
        end
    end

endmodule

>>> rtl/isu_queue.sv
// short command queue between the front stage and the table engine
`timescale 1ns / 1ps

module isu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  isu_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output isu_pkg::t_cmd o_cmd
);
    import isu_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FW = $clog2(QDEPTH + 1);

    t_cmd          r_slots [QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [FW-1:0] r_fill;

    assign o_full  = (r_fill == FW'(QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/isu_back.sv
// table engine: scans the entry memory, applies the operation, holds the result
`timescale 1ns / 1ps

module isu_back #(
    parameter int CAPACITY = isu_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  isu_pkg::t_cmd                i_cmd,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_ok,
    output logic [isu_pkg::COUNT_W-1:0]  o_count
);
    import isu_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EXT_W = CW + COUNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_MOVE
    } t_state;

    t_state                 r_state;
    t_op                    r_op;
    logic [VALUE_W-1:0]     r_value;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_issue;
    logic                   r_cmp_valid;
    logic [AW-1:0]          r_slot;
    logic                   r_res_valid;
    logic                   r_res_ok;
    logic [COUNT_W-1:0]     r_res_count;

    logic [VALUE_W-1:0]     r_mem [CAPACITY];
    logic [VALUE_W-1:0]     r_rd_data;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_W-1:0]     wr_data;

    logic                   cmp_hit;
    logic                   resolved;
    logic [CW-1:0]          issue_m1;
    logic [CW-1:0]          cnt_inc;
    logic [CW-1:0]          cnt_dec;
    logic [EXT_W-1:0]       ext_same;
    logic [EXT_W-1:0]       ext_inc;
    logic [EXT_W-1:0]       ext_dec;

    assign o_pop    = (r_state == ST_IDLE) && i_cmd_valid && !r_res_valid;
    assign o_valid  = r_res_valid;
    assign o_ok     = r_res_ok;
    assign o_count  = r_res_count;

    assign cmp_hit  = r_cmp_valid && (r_rd_data == r_value);
    assign resolved = cmp_hit || (r_issue == r_count);
    assign issue_m1 = r_issue - CW'(1);
    assign cnt_inc  = r_count + CW'(1);
    assign cnt_dec  = r_count - CW'(1);
    assign ext_same = {{COUNT_W{1'b0}}, r_count};
    assign ext_inc  = {{COUNT_W{1'b0}}, cnt_inc};
    assign ext_dec  = {{COUNT_W{1'b0}}, cnt_dec};

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_issue[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = r_rd_data;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_SCAN: begin
                if (!resolved) begin
                    rd_en = 1'b1;
                end else if (r_op == OP_INSERT && !cmp_hit) begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[AW-1:0];
                    wr_data = r_value;
                end
            end
            ST_LAST: begin
                rd_en   = 1'b1;
                rd_addr = cnt_dec[AW-1:0];
            end
            ST_MOVE: begin
                wr_en = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && !i_stall) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_op        <= i_cmd.op;
                        r_value     <= i_cmd.value;
                        r_issue     <= '0;
                        r_cmp_valid <= 1'b0;
                        if (i_cmd.op == OP_NONE ||
                            (i_cmd.op == OP_INSERT && r_count == CAP_C)) begin
                            r_res_valid <= 1'b1;
                            r_res_ok    <= 1'b0;
                            r_res_count <= ext_same[COUNT_W-1:0];
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!resolved) begin
                        r_issue     <= r_issue + CW'(1);
                        r_cmp_valid <= 1'b1;
                    end else begin
                        unique case (r_op)
                            OP_INSERT: begin
                                r_state     <= ST_IDLE;
                                r_res_valid <= 1'b1;
                                r_res_ok    <= !cmp_hit;
                                if (cmp_hit) begin
                                    r_res_count <= ext_same[COUNT_W-1:0];
                                end else begin
                                    r_count     <= cnt_inc;
                                    r_res_count <= ext_inc[COUNT_W-1:0];
                                end
                            end
                            OP_ERASE: begin
                                if (cmp_hit) begin
                                    r_slot  <= issue_m1[AW-1:0];
                                    r_state <= ST_LAST;
                                end else begin
                                    r_state     <= ST_IDLE;
                                    r_res_valid <= 1'b1;
                                    r_res_ok    <= 1'b0;
                                    r_res_count <= ext_same[COUNT_W-1:0];
                                end
                            end
                            default: begin
                                r_state     <= ST_IDLE;
                                r_res_valid <= 1'b1;
                                r_res_ok    <= cmp_hit;
                                r_res_count <= ext_same[COUNT_W-1:0];
                            end
                        endcase
                    end
                end
                ST_LAST: begin
                    r_state <= ST_MOVE;
                end
                ST_MOVE: begin
                    r_count     <= cnt_dec;
                    r_state     <= ST_IDLE;
                    r_res_valid <= 1'b1;
                    r_res_ok    <= 1'b1;
                    r_res_count <= ext_dec[COUNT_W-1:0];
                end
            endcase
        end
    end

endmodule

>>> rtl/integer_set_table_unit.sv
// top level of the integer set table unit: front stage, command queue, table engine
// an input transfer passes the front stage register and the command queue, then the engine scans the n held entries
// erase that finds its value then moves the last entry into the freed slot
// insert into a full table and the unused mode give a failed result without a memory scan
// the engine takes a new command only once the last result has been taken; the scan reads one entry per cycle
// reset clears the entry count and all handshake state; the entry memory is not cleared
`timescale 1ns / 1ps

module integer_set_table_unit #(
    parameter int CAPACITY = isu_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [isu_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [isu_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_ok,
    output logic [isu_pkg::COUNT_W-1:0]         o_count
);
    import isu_pkg::*;

    logic full;
    logic push;
    t_cmd front_cmd;
    logic pop;
    logic q_valid;
    t_cmd q_cmd;

    isu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .i_value (i_value),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    isu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    isu_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_ok        (o_ok),
        .o_count     (o_count)
    );

endmodule

>>> rtl/isu_checker.sv
// port-level assertions for the integer set table unit and their bind
`timescale 1ns / 1ps

module isu_checker #(
    parameter int CAPACITY = isu_pkg::DEF_CAPACITY
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic                                o_ok,
    input logic [isu_pkg::COUNT_W-1:0]         o_count
);
    import isu_pkg::*;

    logic               in_xfer;
    logic               out_xfer;
    logic [3:0]         r_pending;
    logic [COUNT_W-1:0] r_last_count;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_last_count <= '0;
        end else begin
            if (in_xfer && !out_xfer) begin
                r_pending <= r_pending + 4'd1;
            end else if (out_xfer && !in_xfer) begin
                r_pending <= r_pending - 4'd1;
            end
            if (out_xfer) begin
                r_last_count <= o_count;
            end
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok) && $stable(o_count))
        else $error("result changed while stalled");

    // no result without an outstanding item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 4'd0)
        else $error("result without an outstanding item");

    // failed operation leaves the count alone
    a_fail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_count == r_last_count)
        else $error("count moved on a failed operation");

    // count moves by at most one per result
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count == r_last_count) || (o_count == r_last_count + 7'd1) ||
                    (o_count == r_last_count - 7'd1))
        else $error("count moved by more than one");

    // count stays within capacity, checked for capacities up to 127
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CAPACITY > 127) || (int'(o_count) <= CAPACITY))
        else $error("count above capacity");

endmodule

bind integer_set_table_unit isu_checker #(
    .CAPACITY (CAPACITY)
) u_isu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_ok    (o_ok),
    .o_count (o_count)
);

>>> sim/integer_set_table_unit_tb.sv
// self-checking testbench for the integer set table unit with a built-in set predictor
`timescale 1ns / 1ps

module integer_set_table_unit_tb;
    import isu_pkg::*;

    localparam int CAP        = DEF_CAPACITY;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = CAP + 16;
    localparam int POOL_N     = CAP + 16;
    localparam int PHASES     = 9;
    localparam int PHASE_LEN  = 150;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
        bit                 drain;
    } t_set_req;

    typedef struct {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } t_set_rsp;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [MODE_W-1:0]          i_mode;
    logic signed [VALUE_W-1:0]  i_value;
    logic                       o_valid;
    logic                       i_stall;
    logic                       o_ok;
    logic [COUNT_W-1:0]         o_count;

    t_set_req           pending_reqs[$];
    t_set_rsp           expected_rsps[$];
    logic [VALUE_W-1:0] held[CAP];
    int                 held_n;
    logic [VALUE_W-1:0] value_pool[POOL_N];

    bit rst_done;
    bit xfer_done;
    int err_count;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_run;
    int cyc;

    integer_set_table_unit #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ok    (o_ok),
        .o_count (o_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic int slot_of(logic [VALUE_W-1:0] v);
        for (int k = 0; k < held_n; k++) begin
            if (held[k] == v) return k;
        end
        return held_n;
    endfunction

    function automatic t_set_rsp apply_set_op(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] v);
        t_set_rsp r;
        int       s;
        r.ok = 1'b0;
        case (mode)
            MODE_INSERT: begin
                if (held_n < CAP && slot_of(v) == held_n) begin
                    held[held_n] = v;
                    held_n++;
                    r.ok = 1'b1;
                end
            end
            MODE_ERASE: begin
                s = slot_of(v);
                if (s < held_n) begin
                    held[s] = held[held_n-1];
                    held_n--;
                    r.ok = 1'b1;
                end
            end
            MODE_LOOKUP: begin
                r.ok = (slot_of(v) < held_n);
            end
            default: ;
        endcase
        r.count = COUNT_W'(held_n);
        return r;
    endfunction

    task automatic queue_req(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] v, bit drain);
        t_set_req q;
        q.mode  = mode;
        q.value = v;
        q.drain = drain;
        pending_reqs.push_back(q);
    endtask

    // sender: bursts with gaps, holds the payload until the transfer
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (!(i_valid && !xfer_done)) begin
                xfer_done = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() == 0 ||
                             (pending_reqs[0].drain && expected_rsps.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_mode  <= pending_reqs[0].mode;
                    i_value <= pending_reqs[0].value;
                    void'(pending_reqs.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver stall pattern, cycling through no stall, sparse stalls, random half stalls and stall bursts
    always @(negedge i_clk) begin
        bit st;
        cyc++;
        st = 1'b0;
        case ((cyc >> 8) & 3)
            0: st = 1'b0;
            1: st = ($urandom_range(3) == 0);
            2: st = $urandom_range(1);
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    st = 1'b1;
                end else if ($urandom_range(15) == 0) begin
                    stall_run = $urandom_range(1, 20);
                    st = 1'b1;
                end
            end
        endcase
        i_stall <= st;
    end

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        t_set_rsp e;
        if (rst_done) begin
            if (i_valid && !o_stall) begin
                expected_rsps.push_back(apply_set_op(i_mode, i_value));
                xfer_done = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (expected_rsps.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result ok %0b count %0d", $time, o_ok, o_count);
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_ok !== e.ok) begin
                        err_count++;
                        $display("%0t: ok mismatch expected %0b actual %0b",
                                 $time, e.ok, o_ok);
                    end
                    if (o_count !== e.count) begin
                        err_count++;
                        $display("%0t: count mismatch expected %0d actual %0d",
                                 $time, e.count, o_count);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("** integer_set_table_unit: FAILED **");
        $finish;
    end

    initial begin
        int r;
        int kind;
        logic [MODE_W-1:0]  m;
        logic [VALUE_W-1:0] v;
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_mode     = MODE_INSERT;
        i_value    = '0;
        held_n     = 0;
        burst_left = 1;
        gap_left   = 0;

        // directed: empty table, extremes, duplicates, erase of last and of first entry
        queue_req(MODE_LOOKUP, 32'h0000_0000, 1'b0);
        queue_req(MODE_ERASE,  32'h0000_0005, 1'b0);
        queue_req(MODE_UNUSED, 32'h0000_0000, 1'b0);
        queue_req(MODE_INSERT, 32'h8000_0000, 1'b0);
        queue_req(MODE_INSERT, 32'h7fff_ffff, 1'b0);
        queue_req(MODE_INSERT, 32'h0000_0000, 1'b0);
        queue_req(MODE_INSERT, 32'hffff_ffff, 1'b0);
        queue_req(MODE_INSERT, 32'h7fff_ffff, 1'b0);
        queue_req(MODE_LOOKUP, 32'h8000_0000, 1'b0);
        queue_req(MODE_LOOKUP, 32'h0000_0001, 1'b0);
        queue_req(MODE_ERASE,  32'hffff_ffff, 1'b0);
        queue_req(MODE_ERASE,  32'h8000_0000, 1'b0);
        queue_req(MODE_LOOKUP, 32'h0000_0000, 1'b0);
        queue_req(MODE_LOOKUP, 32'h7fff_ffff, 1'b0);
        queue_req(MODE_ERASE,  32'h8000_0000, 1'b0);
        queue_req(MODE_UNUSED, 32'h55aa_55aa, 1'b0);
        queue_req(MODE_INSERT, 32'haaaa_aaaa, 1'b0);
        queue_req(MODE_INSERT, 32'h5555_5555, 1'b0);
        queue_req(MODE_ERASE,  32'h0000_0000, 1'b0);
        queue_req(MODE_ERASE,  32'h7fff_ffff, 1'b0);
        queue_req(MODE_ERASE,  32'haaaa_aaaa, 1'b0);
        queue_req(MODE_ERASE,  32'h5555_5555, 1'b0);

        // random phases over a slowly changing value pool: fill, churn, drain
        for (int k = 0; k < POOL_N; k++) value_pool[k] = $urandom;
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int k = 0; k < POOL_N / 4; k++) value_pool[$urandom_range(POOL_N-1)] = $urandom;
            kind = ph % 3;
            for (int n = 0; n < PHASE_LEN; n++) begin
                r = $urandom_range(99);
                if (r < 3) m = MODE_UNUSED;
                else if (kind == 0)
                    m = (r < 78) ? MODE_INSERT : (r < 83) ? MODE_ERASE : MODE_LOOKUP;
                else if (kind == 1)
                    m = (r < 38) ? MODE_INSERT : (r < 73) ? MODE_ERASE : MODE_LOOKUP;
                else
                    m = (r < 18) ? MODE_INSERT : (r < 73) ? MODE_ERASE : MODE_LOOKUP;
                v = ($urandom_range(99) < 92) ? value_pool[$urandom_range(POOL_N-1)] : $urandom;
                queue_req(m, v, n == 0);
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        while (pending_reqs.size() != 0 || i_valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (err_count == 0)
            $display("** integer_set_table_unit: PASSED **");
        else
            $display("** integer_set_table_unit: FAILED **");
        $finish;
    end

endmodule
